@@ hw/rtl/csvtok_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvtok_pkg: shared types and constants for the CSV field tokenizer
// Character codes, line phase encoding, register indexes and default sizes.
// ----------------------------------------------------------------------------
package csvtok_pkg;

	localparam int DEF_MAX_COLUMNS   = 64;
	localparam int DEF_POSITION_BITS = 16;

	// Depth of the record queue between the front and back parts.
	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_COMMA  = 8'h2C;

	localparam logic [6:0] RST_MAX_COLUMNS = 7'd64;

	typedef enum logic {
		CFG_FIELD_DELIMITER = 1'b0,
		CFG_MAX_COLUMNS     = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		PH_LEAD    = 2'd0,
		PH_PEND    = 2'd1,
		PH_CONTENT = 2'd2,
		PH_COMMENT = 2'd3
	} line_phase_t;

endpackage

@@ hw/rtl/csvtok_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvtok_front: byte classifier and line/field state
// Accepts one text byte per cycle while accept is high and emits up to two field records.
// ----------------------------------------------------------------------------
module csvtok_front import csvtok_pkg::*; #(
	parameter int MAX_COLUMNS   = DEF_MAX_COLUMNS,
	parameter int POSITION_BITS = DEF_POSITION_BITS,
	localparam int REC_W        = 3 * POSITION_BITS + 41
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [7:0]       cfg_wdata,
	input  logic             accept,
	input  logic [7:0]       data_byte,
	input  logic             end_of_input,
	output logic [1:0]       push_count,
	output logic [REC_W-1:0] rec0,
	output logic [REC_W-1:0] rec1
);

	localparam int P     = POSITION_BITS;
	localparam int COL_W = $clog2(MAX_COLUMNS + 1);
	localparam int LIM_W = ((COL_W > 7) ? COL_W : 7) + 1;
	localparam logic [P-1:0] PMAX = {P{1'b1}};

	typedef struct packed {
		logic         seen;
		logic [P-1:0] trim_first;
		logic [P-1:0] trim_last;
		logic [7:0]   first_char;
		logic [7:0]   last_char;
		logic [P-1:0] blank_start;
		logic [5:0]   column;
		logic [15:0]  row;
		logic         last;
		logic         long_line;
	} rec_t;

	logic [7:0]       delim_q;
	logic [6:0]       maxcol_q;
	line_phase_t      phase_q, phase_n;
	logic             quote_q, quote_n;
	logic [COL_W-1:0] col_q, col_n;
	logic [P-1:0]     pos_q, pos_n;
	logic [P-1:0]     tf_q, tf_n;
	logic [P-1:0]     tl_q, tl_n;
	logic [7:0]       fc_q, fc_n;
	logic [7:0]       lc_q, lc_n;
	logic             seen_q, seen_n;
	logic [15:0]      row_q, row_n;
	logic             full_q, full_n;
	logic [P-1:0]     nocr_q, nocr_n;
	logic             long_q, long_n;

	rec_t             rec_a, rec_b;
	logic             emit_a, emit_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q  <= CH_COMMA;
			maxcol_q <= RST_MAX_COLUMNS;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_FIELD_DELIMITER: delim_q <= cfg_wdata;
				CFG_MAX_COLUMNS:     maxcol_q <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			quote_q <= 1'b0;
			col_q   <= '0;
			pos_q   <= '0;
			seen_q  <= 1'b0;
			row_q   <= '0;
			full_q  <= 1'b0;
			nocr_q  <= '0;
			long_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_n;
			quote_q <= quote_n;
			col_q   <= col_n;
			pos_q   <= pos_n;
			seen_q  <= seen_n;
			row_q   <= row_n;
			full_q  <= full_n;
			nocr_q  <= nocr_n;
			long_q  <= long_n;
		end
	end

	// The trim markers and edge characters only matter once seen is set,
	// and they are all loaded at that moment, so they carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			tf_q <= tf_n;
			tl_q <= tl_n;
			fc_q <= fc_n;
			lc_q <= lc_n;
		end
	end

	logic             is_nl, is_quote, blank, split, active, end_ln, last_a;
	logic [P-1:0]     pos_inc;
	logic [LIM_W-1:0] lim;

	always_comb begin
		if (maxcol_q == 7'd0) begin
			lim = LIM_W'(1);
		end else if (LIM_W'(maxcol_q) > LIM_W'(MAX_COLUMNS)) begin
			lim = LIM_W'(MAX_COLUMNS);
		end else begin
			lim = LIM_W'(maxcol_q);
		end
	end

	always_comb begin
		phase_n  = phase_q;
		quote_n  = quote_q;
		col_n    = col_q;
		pos_n    = pos_q;
		tf_n     = tf_q;
		tl_n     = tl_q;
		fc_n     = fc_q;
		lc_n     = lc_q;
		seen_n   = seen_q;
		row_n    = row_q;
		full_n   = full_q;
		nocr_n   = nocr_q;
		long_n   = long_q;

		is_nl    = (data_byte == CH_NL);
		is_quote = (data_byte == CH_DQUOTE);
		blank    = (data_byte == CH_SPACE) || (data_byte == CH_TAB) || (data_byte == CH_CR);
		pos_inc  = (pos_q == PMAX) ? PMAX : pos_q + P'(1);
		split    = !is_quote && (data_byte == delim_q) && (data_byte != CH_CR) && !quote_q;
		last_a   = (LIM_W'(col_q) + LIM_W'(1)) >= lim;

		// Field that a delimiter closes, taken from the state before this byte.
		rec_a.seen        = seen_q;
		rec_a.trim_first  = tf_q;
		rec_a.trim_last   = tl_q;
		rec_a.first_char  = fc_q;
		rec_a.last_char   = lc_q;
		rec_a.blank_start = pos_q;
		rec_a.column      = 6'(col_q);
		rec_a.row         = row_q;
		rec_a.last        = last_a;
		rec_a.long_line   = long_q;

		if (!is_nl) begin
			case (phase_q)
				PH_LEAD: begin
					if (data_byte == CH_SPACE || data_byte == CH_TAB) begin
						if (data_byte == delim_q) phase_n = PH_CONTENT;
					end else if (data_byte == CH_CR) begin
						phase_n = PH_PEND;
					end else if (data_byte == CH_HASH) begin
						phase_n = PH_COMMENT;
					end else begin
						phase_n = PH_CONTENT;
					end
				end
				PH_PEND: begin
					if (data_byte != CH_CR) phase_n = PH_CONTENT;
				end
				default: ;
			endcase
		end
		active = !is_nl && (phase_n != PH_COMMENT) && !full_q;
		emit_a = active && split;

		if (active) begin
			if (split) begin
				col_n   = col_q + COL_W'(1);
				if (last_a) full_n = 1'b1;
				quote_n = 1'b0;
				seen_n  = 1'b0;
				nocr_n  = pos_inc;
			end else begin
				if (is_quote) quote_n = ~quote_q;
				if (!blank) begin
					if (!seen_q) begin
						tf_n   = pos_q;
						fc_n   = data_byte;
						seen_n = 1'b1;
					end
					tl_n = pos_inc;
					lc_n = data_byte;
				end
				if (data_byte != CH_CR) nocr_n = pos_inc;
			end
		end

		if (!is_nl) begin
			if (pos_q == PMAX) long_n = 1'b1;
			else pos_n = pos_q + P'(1);
		end

		// Field that the end of the line closes, from the state after this byte.
		end_ln = is_nl || end_of_input;
		emit_b = end_ln && (phase_n == PH_CONTENT) && !full_n;
		rec_b.seen        = seen_n;
		rec_b.trim_first  = tf_n;
		rec_b.trim_last   = tl_n;
		rec_b.first_char  = fc_n;
		rec_b.last_char   = lc_n;
		rec_b.blank_start = nocr_n;
		rec_b.column      = 6'(col_n);
		rec_b.row         = row_q;
		rec_b.last        = 1'b1;
		rec_b.long_line   = long_n;

		if (end_ln) begin
			if (phase_n == PH_CONTENT && row_q != 16'hFFFF) row_n = row_q + 16'd1;
			phase_n = PH_LEAD;
			col_n   = '0;
			pos_n   = '0;
			full_n  = 1'b0;
			long_n  = 1'b0;
			quote_n = 1'b0;
			seen_n  = 1'b0;
			nocr_n  = '0;
		end
	end

	assign push_count = accept ? (2'(emit_a) + 2'(emit_b)) : 2'd0;
	assign rec0       = emit_a ? rec_a : rec_b;
	assign rec1       = rec_b;

endmodule

@@ hw/rtl/csvtok_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvtok_queue: record queue between front and back
// Takes up to two records per cycle and releases one per cycle while pop is high.
// ----------------------------------------------------------------------------
module csvtok_queue import csvtok_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_count,
	input  logic [WIDTH-1:0] din0,
	input  logic [WIDTH-1:0] din1,
	output logic             room2,
	input  logic             pop,
	output logic             nonempty,
	output logic [WIDTH-1:0] dout
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(push_count);
			if (pop) rd_q <= rd_q + PTR_W'(1);
			cnt_q <= cnt_q + CNT_W'(push_count) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_count != 2'd0) slot_q[wr_q] <= din0;
		if (push_count == 2'd2) slot_q[wr_q + PTR_W'(1)] <= din1;
	end

	assign room2    = cnt_q <= CNT_W'(QUEUE_DEPTH - 2);
	assign nonempty = cnt_q != '0;
	assign dout     = slot_q[rd_q];

endmodule

@@ hw/rtl/csvtok_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvtok_back: field result builder and output register
// Trims, strips enclosing quotes and presents one result word per cycle while records wait and m_tready is high.
// ----------------------------------------------------------------------------
module csvtok_back import csvtok_pkg::*; #(
	parameter int POSITION_BITS = DEF_POSITION_BITS,
	localparam int REC_W        = 3 * POSITION_BITS + 41
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             nonempty,
	input  logic [REC_W-1:0] head,
	output logic             pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [55:0]      m_tdata,
	output logic             m_tlast,
	output logic [0:0]       m_tuser
);

	localparam int P = POSITION_BITS;

	typedef struct packed {
		logic         seen;
		logic [P-1:0] trim_first;
		logic [P-1:0] trim_last;
		logic [7:0]   first_char;
		logic [7:0]   last_char;
		logic [P-1:0] blank_start;
		logic [5:0]   column;
		logic [15:0]  row;
		logic         last;
		logic         long_line;
	} rec_t;

	rec_t         rec;
	logic [P-1:0] len, start, len_out;
	logic         strip;

	assign rec = head;

	always_comb begin
		len   = (rec.trim_last > rec.trim_first) ? rec.trim_last - rec.trim_first : '0;
		strip = (len >= P'(2)) && (rec.first_char == rec.last_char) &&
		        ((rec.first_char == CH_DQUOTE) || (rec.first_char == CH_SQUOTE));
		if (!rec.seen) begin
			start   = rec.blank_start;
			len_out = '0;
		end else if (strip) begin
			start   = rec.trim_first + P'(1);
			len_out = len - P'(2);
		end else begin
			start   = rec.trim_first;
			len_out = len;
		end
	end

	assign pop = nonempty && (!m_tvalid || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (!m_tvalid || m_tready) begin
			m_tvalid <= nonempty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			m_tdata <= {2'b00, rec.row, 16'(len_out), 16'(start), rec.column};
			m_tlast <= rec.last;
			m_tuser <= rec.long_line;
		end
	end

endmodule

@@ hw/rtl/csv_field_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_field_tokenizer: CSV/TSV field tokenizer
// Splits a byte stream into lines and fields and reports each kept field.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Word contents
//  cfg       in         cfg_we, cfg_index (0 delimiter, 1 column limit), cfg_wdata
//  s_axis    in         tdata: data_byte; tlast: end of input
//  m_axis    out        tdata: column, field_offset, field_length, row_index;
//                       tlast: row end; tuser: long line
//
// One byte is taken per cycle while s_axis_tready is high; the front part finishes
// a byte in the cycle it is accepted. A byte can close two fields (a delimiter that
// is also the last byte of input), which leave the output register one word at a
// time, so the sustained rate is one byte per cycle as long as that is rare.
// The four-entry record queue lets the input keep running for a while when the
// output stalls; s_axis_tready drops once fewer than two entries are free.
// Reset clears the line state, the row counter, the record queue and the output
// valid flag; the delimiter returns to comma and the column limit to 64.
//
// A delimiter inside double quotes does not split. Each field is trimmed of
// space, tab and CR, then one matching pair of enclosing quotes is removed.
// Blank lines and lines with '#' after any leading spaces or tabs produce no words.
module csv_field_tokenizer import csvtok_pkg::*; #(
	parameter int MAX_COLUMNS   = DEF_MAX_COLUMNS,
	parameter int POSITION_BITS = DEF_POSITION_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // [5:0] column, [21:6] field_offset,
	                                    // [37:22] field_length, [53:38] row_index
	output logic        m_axis_tlast,
	output logic [0:0]  m_axis_tuser    // [0] long_line
);

	localparam int REC_W = 3 * POSITION_BITS + 41;

	logic             accept;
	logic [1:0]       push_count;
	logic [REC_W-1:0] rec0, rec1, head;
	logic             room2, nonempty, pop;

	// A byte is taken only when the queue can hold both records it may cause.
	assign s_axis_tready = room2;
	assign accept        = s_axis_tvalid && room2;

	csvtok_front #(
		.MAX_COLUMNS  (MAX_COLUMNS),
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.accept      (accept),
		.data_byte   (s_axis_tdata),
		.end_of_input(s_axis_tlast),
		.push_count  (push_count),
		.rec0        (rec0),
		.rec1        (rec1)
	);

	csvtok_queue #(
		.WIDTH(REC_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_count(push_count),
		.din0      (rec0),
		.din1      (rec1),
		.room2     (room2),
		.pop       (pop),
		.nonempty  (nonempty),
		.dout      (head)
	);

	// The back part turns each record into the trimmed start and length.
	csvtok_back #(
		.POSITION_BITS(POSITION_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.nonempty(nonempty),
		.head    (head),
		.pop     (pop),
		.m_tvalid(m_axis_tvalid),
		.m_tready(m_axis_tready),
		.m_tdata (m_axis_tdata),
		.m_tlast (m_axis_tlast),
		.m_tuser (m_axis_tuser)
	);

endmodule

@@ tb/sv/tb_csv_field_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_csv_field_tokenizer: self-checking testbench for the CSV field tokenizer
// Streams text bytes into the block and predicts every field word with a
// behavioral tokenizer kept in step with the register writes. Each word that
// leaves the block is compared field by field against the oldest prediction.
// The run covers directed quoting, trimming and delimiter cases and random
// lines with random back-pressure and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_csv_field_tokenizer;
	import csvtok_pkg::*;

	// No word in either direction for this many cycles means the block hung.
	// The longest legal quiet stretch is the receiver hold-off.
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int IDLE_PERCENT = 9;
	localparam int RANDOM_PHASE_BYTES = 110;

	localparam logic [7:0] CH_LOWER_A = "a";
	localparam logic [7:0] CH_DIGIT_0 = "0";
	localparam logic [7:0] CH_SEMI = ";";
	localparam logic [7:0] CH_PIPE = "|";

	typedef logic [DEF_POSITION_BITS-1:0] pos_t;

	// One predicted field word, in the order the block reports the fields.
	typedef struct packed {
		logic [5:0]  column;
		logic [15:0] start;
		logic [15:0] length;
		logic [15:0] row;
		logic        row_end;
		logic        long_line;
	} field_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	cfg_index_t  cfg_index = CFG_FIELD_DELIMITER;
	logic [7:0]  cfg_wdata = 8'h00;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;    // [7:0] data_byte
	logic        s_axis_tlast = 1'b0;     // end of input
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;            // [5:0] column, [21:6] field_offset,
	                                      // [37:22] field_length, [53:38] row_index
	logic        m_axis_tlast;            // row end
	logic [0:0]  m_axis_tuser;            // [0] long_line

	csv_field_tokenizer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #10 clk = ~clk;

	// Fields the block still owes us, oldest first.
	field_word_t expected_fields[$];

	int unsigned bytes_sent = 0;
	int unsigned words_checked = 0;
	int unsigned reg_writes = 0;
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;

	// Random idling on both sides is switched off for a stretch of the run.
	bit idle_enable = 1'b1;
	// The main sequence asks for a receiver hold-off; the output process counts it.
	bit hold_request = 1'b0;
	int hold_left = 0;

	// ------------------------------------------------------------------------
	// Behavioral tokenizer: register copies and per-line state.
	// ------------------------------------------------------------------------
	logic [7:0]  delim_reg;
	logic [6:0]  colmax_reg;
	bit          in_quotes;
	line_phase_t phase;
	logic [6:0]  col_count;
	pos_t        line_pos;
	pos_t        trim_lo;
	pos_t        trim_hi;
	pos_t        content_end;    // just past the last non-CR byte of the field
	logic [7:0]  first_ch;
	logic [7:0]  last_ch;
	bit          has_content;
	logic [15:0] rows_seen;
	bit          row_done;
	bit          line_saturated;

	function automatic pos_t step_pos(pos_t p);
		return (p == '1) ? p : p + 1'b1;
	endfunction

	// A limit of zero behaves as one, and anything past the hardware size clips.
	function int column_limit();
		int m;
		m = int'(colmax_reg);
		if (m == 0)
			m = 1;
		if (m > DEF_MAX_COLUMNS)
			m = DEF_MAX_COLUMNS;
		return m;
	endfunction

	function void open_field(pos_t at);
		in_quotes = 1'b0;
		trim_lo = at;
		trim_hi = at;
		content_end = at;
		first_ch = 8'h00;
		last_ch = 8'h00;
		has_content = 1'b0;
	endfunction

	function void open_line();
		phase = PH_LEAD;
		col_count = '0;
		line_pos = '0;
		row_done = 1'b0;
		line_saturated = 1'b0;
		open_field('0);
	endfunction

	// A field with no visible byte reports zero length at blank_start. Otherwise
	// the trimmed span is used, minus one matching pair of enclosing quotes.
	function void record_field(pos_t blank_start, bit is_last);
		field_word_t w;
		pos_t        s;
		pos_t        n;
		s = blank_start;
		n = '0;
		if (has_content) begin
			s = trim_lo;
			n = (trim_hi > trim_lo) ? trim_hi - trim_lo : '0;
			if (n >= 2 && first_ch == last_ch &&
			    (first_ch == CH_DQUOTE || first_ch == CH_SQUOTE)) begin
				s = s + 1'b1;
				n = n - 2'd2;
			end
		end
		w.column = col_count[5:0];
		w.start = s[15:0];
		w.length = n[15:0];
		w.row = rows_seen;
		w.row_end = is_last;
		w.long_line = line_saturated;
		expected_fields.push_back(w);
	endfunction

	// A content line that is not already full closes with one last field.
	function void close_line();
		if (phase == PH_CONTENT) begin
			if (!row_done)
				record_field(content_end, 1'b1);
			if (rows_seen != 16'hFFFF)
				rows_seen++;
		end
		open_line();
	endfunction

	function void tokenize_byte(logic [7:0] b, bit eoi);
		bit   blank;
		bit   split;
		bit   is_last;
		pos_t p;
		blank = (b == CH_SPACE || b == CH_TAB || b == CH_CR);
		if (b == CH_NL) begin
			close_line();
			return;
		end
		// Decide what kind of line this is from its leading bytes. A blank
		// delimiter among the leading blanks already makes it a content line.
		case (phase)
			PH_LEAD: begin
				if (b == CH_SPACE || b == CH_TAB) begin
					if (b == delim_reg)
						phase = PH_CONTENT;
				end else if (b == CH_CR)
					phase = PH_PEND;
				else if (b == CH_HASH)
					phase = PH_COMMENT;
				else
					phase = PH_CONTENT;
			end
			PH_PEND: begin
				if (b != CH_CR)
					phase = PH_CONTENT;
			end
			default: ;
		endcase
		if (phase != PH_COMMENT && !row_done) begin
			p = line_pos;
			split = 1'b0;
			if (b == CH_DQUOTE)
				in_quotes = !in_quotes;
			else if (b == delim_reg && b != CH_CR && !in_quotes)
				split = 1'b1;
			if (split) begin
				is_last = (col_count + 1 >= column_limit());
				record_field(p, is_last);
				col_count++;
				if (is_last)
					row_done = 1'b1;
				open_field(step_pos(p));
			end else begin
				if (!blank) begin
					if (!has_content) begin
						trim_lo = p;
						first_ch = b;
						has_content = 1'b1;
					end
					trim_hi = step_pos(p);
					last_ch = b;
				end
				if (b != CH_CR)
					content_end = step_pos(p);
			end
		end
		if (line_pos == '1)
			line_saturated = 1'b1;
		else
			line_pos++;
		if (eoi)
			close_line();
	endfunction

	// ------------------------------------------------------------------------
	// Output side: random back-pressure, hold-off and field-by-field compare.
	// ------------------------------------------------------------------------
	function void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	function void check_word();
		field_word_t want;
		if (expected_fields.size() == 0) begin
			$error("field word with no expectation: tdata %h", m_axis_tdata);
			mismatches++;
			return;
		end
		want = expected_fields.pop_front();
		words_checked++;
		compare_field("column", want.column, m_axis_tdata[5:0]);
		compare_field("field_offset", want.start, m_axis_tdata[21:6]);
		compare_field("field_length", want.length, m_axis_tdata[37:22]);
		compare_field("row_index", want.row, m_axis_tdata[53:38]);
		compare_field("row_end", want.row_end, m_axis_tlast);
		compare_field("long_line", want.long_line, m_axis_tuser[0]);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				check_word();
			if (hold_request) begin
				hold_left = HOLD_OFF_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else
				m_axis_tready <= !(idle_enable && $urandom_range(99) < IDLE_PERCENT);
		end
	end

	// Watchdog: a run of cycles with no word moving on either side is a hang.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$error("no word moved for %0d cycles, %0d fields outstanding",
			       quiet_cycles, expected_fields.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Input side helpers.
	// ------------------------------------------------------------------------

	// Offers one byte and waits for the handshake, then predicts its fields.
	// tvalid stays high on return so back-to-back bytes need no gap; whoever
	// pauses the stream lowers it.
	task send_byte(input logic [7:0] b, input bit eoi);
		if (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= eoi;
		do
			@(posedge clk);
		while (!s_axis_tready);
		bytes_sent++;
		tokenize_byte(b, eoi);
	endtask

	task send_text(input string s, input bit eoi_at_end);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], eoi_at_end && i == s.len() - 1);
	endtask

	// Stops the stream and waits for every owed field, plus a few cycles in
	// case the last bytes were still being absorbed without producing a word.
	task wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_fields.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task write_reg(input cfg_index_t idx, input logic [7:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
		if (idx == CFG_FIELD_DELIMITER)
			delim_reg = value;
		else
			colmax_reg = value[6:0];
	endtask

	task apply_reset();
		delim_reg = CH_COMMA;
		colmax_reg = RST_MAX_COLUMNS;
		rows_seen = '0;
		open_line();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Directed tests.
	// ------------------------------------------------------------------------

	// Default comma split: trimming, a quoted delimiter, quote stripping, a
	// trailing delimiter before CR LF, blank and comment lines, unmatched
	// quotes, the byte extremes and a line closed by end of input.
	task test_field_rules();
		send_text(" a ,\"b,c\" , 'd' ,\r\n", 1'b0);
		send_text("\n", 1'b0);
		send_text(" \t#x,y\n", 1'b0);
		send_text("'e\",\r\r\n", 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(CH_COMMA, 1'b0);
		send_text("z", 1'b1);
	endtask

	// Column limit of two, zero acting as one, and 127 clipping to 64 on a
	// line of 67 empty fields.
	task test_column_limit();
		write_reg(CFG_MAX_COLUMNS, 8'd2);
		send_text("1,2,3\n", 1'b0);
		write_reg(CFG_MAX_COLUMNS, 8'd0);
		send_text("a,b\n", 1'b0);
		write_reg(CFG_MAX_COLUMNS, 8'd127);
		repeat (66) send_byte(CH_COMMA, 1'b0);
		send_byte(CH_NL, 1'b0);
		write_reg(CFG_MAX_COLUMNS, 8'(RST_MAX_COLUMNS));
	endtask

	// Blank delimiters in the leading blanks, delimiters that never split
	// (CR, double quote, newline), the delimiter byte extremes, and end of
	// input landing on the newline itself.
	task test_delimiters();
		write_reg(CFG_FIELD_DELIMITER, CH_TAB);
		send_text("\tu\tv \n", 1'b0);
		write_reg(CFG_FIELD_DELIMITER, CH_SPACE);
		send_text(" w x\n", 1'b0);
		write_reg(CFG_FIELD_DELIMITER, CH_CR);
		send_text("a\rb\r\n", 1'b0);
		write_reg(CFG_FIELD_DELIMITER, CH_DQUOTE);
		send_text("a\"b\n", 1'b0);
		write_reg(CFG_FIELD_DELIMITER, CH_NL);
		send_text("p,q\n", 1'b0);
		write_reg(CFG_FIELD_DELIMITER, 8'h00);
		send_text("a", 1'b0);
		send_byte(8'h00, 1'b0);
		send_text("b\n", 1'b0);
		write_reg(CFG_FIELD_DELIMITER, 8'hFF);
		send_text("c", 1'b0);
		send_byte(8'hFF, 1'b0);
		send_text("d\n", 1'b0);
		write_reg(CFG_FIELD_DELIMITER, CH_COMMA);
		send_text("c\n", 1'b1);
	endtask

	// ------------------------------------------------------------------------
	// Random lines.
	// ------------------------------------------------------------------------
	function logic [7:0] pick_blank();
		case ($urandom_range(2))
			0: return CH_SPACE;
			1: return CH_TAB;
			default: return CH_CR;
		endcase
	endfunction

	// Mostly printable text, with a fair share of the bytes the tokenizer
	// treats specially.
	function logic [7:0] pick_text_byte();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return 8'(CH_LOWER_A + $urandom_range(25));
		else if (r < 60)
			return 8'(CH_DIGIT_0 + $urandom_range(9));
		else if (r < 68)
			return CH_SPACE;
		else if (r < 72)
			return CH_TAB;
		else if (r < 75)
			return CH_CR;
		else if (r < 80)
			return CH_DQUOTE;
		else if (r < 85)
			return CH_SQUOTE;
		else if (r < 88)
			return CH_HASH;
		else if (r < 93)
			return delim_reg;
		return 8'($urandom_range(255));
	endfunction

	task send_random_field();
		logic [7:0] q;
		int         r;
		repeat ($urandom_range(0, 2)) send_byte(pick_blank(), 1'b0);
		r = $urandom_range(9);
		q = (r < 2) ? CH_DQUOTE : (r < 4) ? CH_SQUOTE : 8'h00;
		if (q != 8'h00)
			send_byte(q, 1'b0);
		repeat ($urandom_range(0, 5)) send_byte(pick_text_byte(), 1'b0);
		if (q != 8'h00 && $urandom_range(3) != 0)
			send_byte(q, 1'b0);
		repeat ($urandom_range(0, 2)) send_byte(pick_blank(), 1'b0);
	endtask

	// Returns the number of bytes that could produce fields; blank and
	// comment lines do not count.
	task send_random_line(output int useful);
		int kind;
		int n_fields;
		int first;
		first = bytes_sent;
		useful = 0;
		kind = $urandom_range(99);
		if (kind < 8) begin
			// Noise: raw bytes, occasionally flagged as the end of input.
			repeat ($urandom_range(1, 24))
				send_byte(8'($urandom_range(255)), $urandom_range(99) < 3);
			useful = bytes_sent - first;
		end else if (kind < 14) begin
			repeat ($urandom_range(0, 3)) send_byte(pick_blank(), 1'b0);
			if (kind < 11) begin
				send_byte(CH_HASH, 1'b0);
				repeat ($urandom_range(0, 6)) send_byte(pick_text_byte(), 1'b0);
			end
			send_byte(CH_NL, 1'b0);
		end else begin
			// Well-formed line, now and then wider than any column limit.
			n_fields = ($urandom_range(9) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 6);
			for (int i = 0; i < n_fields; i++) begin
				send_random_field();
				if (i != n_fields - 1)
					send_byte(delim_reg, 1'b0);
			end
			if ($urandom_range(9) == 0)
				send_byte(delim_reg, 1'b0);
			repeat ($urandom_range(0, 1)) send_byte(CH_CR, 1'b0);
			case ($urandom_range(39))
				0: send_byte(CH_LOWER_A, 1'b1);
				1: send_byte(CH_NL, 1'b1);
				default: send_byte(CH_NL, 1'b0);
			endcase
			useful = bytes_sent - first;
		end
	endtask

	// Six phases with different register settings. Phase 2 runs with no idling
	// on either side; phase 4 starts with a long receiver hold-off while the
	// sender keeps going, so the record queue fills and tready drops.
	task test_random_lines();
		int         count;
		int         got;
		logic [7:0] delim;
		logic [7:0] limit;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: delim = CH_COMMA;
				1: delim = CH_TAB;
				2: delim = CH_SEMI;
				3: delim = CH_SPACE;
				4: delim = CH_PIPE;
				default: delim = 8'($urandom_range(255));
			endcase
			case ($urandom_range(3))
				0: limit = 8'($urandom_range(1, 4));
				1: limit = 8'($urandom_range(0, 127));
				default: limit = 8'(DEF_MAX_COLUMNS);
			endcase
			write_reg(CFG_FIELD_DELIMITER, delim);
			write_reg(CFG_MAX_COLUMNS, limit);
			idle_enable = (ph != 2);
			if (ph == 4)
				hold_request = 1'b1;
			count = 0;
			while (count < RANDOM_PHASE_BYTES) begin
				send_random_line(got);
				count += got;
			end
		end
		idle_enable = 1'b1;
		// Leave a clean line boundary at the end of the stream.
		send_byte(CH_NL, 1'b0);
	endtask

	initial begin
		apply_reset();
		test_field_rules();
		test_column_limit();
		test_delimiters();
		test_random_lines();
		wait_idle();
		repeat (20) @(posedge clk);
		$display("Run covered %0d bytes, %0d field words checked, %0d register writes.",
		         bytes_sent, words_checked, reg_writes);
		$display("Quoting, trimming, column limits, odd delimiters and output stalls were exercised.");
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/csvtok_pkg.sv
hw/rtl/csvtok_front.sv
hw/rtl/csvtok_queue.sv
hw/rtl/csvtok_back.sv
hw/rtl/csv_field_tokenizer.sv
tb/sv/tb_csv_field_tokenizer.sv
